// ===== rtl/acld_pkg.sv =====
// Shared types and constants of the AC multiplexed LCD driver.
package acld_pkg;

    localparam int FRAME_BYTES = 6;
    localparam int PLANES      = 2;
    localparam int PHASES      = 4;

    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_CLEAR = 2'd1,
        OP_TICK  = 2'd2,
        OP_NONE  = 2'd3
    } t_opcode;

    typedef logic [FRAME_BYTES-1:0][7:0] t_plane;
    typedef logic [PLANES-1:0][FRAME_BYTES-1:0][7:0] t_image;
    typedef logic [PHASES-1:0][FRAME_BYTES-1:0][7:0] t_frames;

    localparam logic [7:0] COM_KEEP_MASK = 8'b11100011;
    localparam logic [7:0] COM_PHASE0    = 8'b00010000;
    localparam logic [7:0] COM_PHASE1    = 8'b00001000;
    localparam logic [7:0] COM_PHASE2    = 8'b00001100;
    localparam logic [7:0] COM_PHASE3    = 8'b00010100;
    localparam logic [7:0] LED_BIT_MASK  = 8'h10;
    localparam logic [7:0] LED_KEEP_MASK = 8'b11101111;
    localparam logic [7:0] LED_BYTE_INIT = 8'h10;
    localparam logic [7:0] ALL_ON        = 8'hff;

    // Register addresses on the configuration port (word index).
    localparam logic REG_KEY_REPORT_ENABLE = 1'b0;

    // Default image: commons of byte 0 preset per plane, LED byte and
    // enable byte fixed, all segments off.
    function automatic t_image default_image();
        t_image img;
        img = '0;
        for (int p = 0; p < PLANES; p++) begin
            img[p][4] = ALL_ON;
            img[p][5] = LED_BYTE_INIT;
        end
        img[0][0] = (COM_PHASE0 & COM_KEEP_MASK) | COM_PHASE3;
        img[1][0] = (COM_PHASE1 & COM_KEEP_MASK) | COM_PHASE2;
        return img;
    endfunction

    // Build the four drive phases from the image: straight and inverted
    // copies, with the enable byte and the LED bit kept true and the common bits forced.
    function automatic t_frames build_frames(input t_image img);
        t_frames f;
        for (int b = 0; b < FRAME_BYTES; b++) begin
            f[0][b] = img[0][b];
            f[1][b] = img[1][b];
            f[2][b] = ~img[0][b];
            f[3][b] = ~img[1][b];
        end
        f[2][4] = f[0][4];
        f[3][4] = f[1][4];
        f[2][5] = (f[0][5] & LED_BIT_MASK) | (f[2][5] & LED_KEEP_MASK);
        f[3][5] = (f[1][5] & LED_BIT_MASK) | (f[3][5] & LED_KEEP_MASK);
        f[0][0] = (f[0][0] & COM_KEEP_MASK) | COM_PHASE0;
        f[1][0] = (f[1][0] & COM_KEEP_MASK) | COM_PHASE1;
        f[2][0] = (f[2][0] & COM_KEEP_MASK) | COM_PHASE2;
        f[3][0] = (f[3][0] & COM_KEEP_MASK) | COM_PHASE3;
        return f;
    endfunction

endpackage

// ===== rtl/ac_lcd_multiplex_driver_top.sv =====
// Top level of the AC multiplexed LCD driver with button scan.
// A tick request shows its result on the registered outputs right after the
// clock edge that accepts it; write and clear requests give none.
// One request per cycle unless a stalled result holds the single output register.
// Reset (synchronous, active low) restores the default image, zeroes the phase
// frames, tick count and button bits, marks the image changed and disables
// key reporting. No clearing pass is needed: all state lives in flip-flops.
module ac_lcd_multiplex_driver_top
    import acld_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request channel
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_opcode,
    input  logic [7:0]  i_segment_command,
    input  logic        i_segment_on,
    input  logic        i_button_level,
    // result channel
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_scan_select,
    output logic [47:0] o_phase_frame,
    output logic [7:0]  o_button_state,
    output logic [7:0]  o_button_previous,
    output logic        o_key_event,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // Architectural state.
    t_image      r_image, n_image;
    t_frames     r_frames, n_frames;
    logic        r_changed, n_changed;
    logic [2:0]  r_tick, n_tick;
    logic [7:0]  r_buttons, n_buttons;
    logic [7:0]  r_reported, n_reported;
    logic        r_key_en;

    // Result register.
    logic        r_out_valid, n_out_valid;
    logic [7:0]  r_scan_select, n_scan_select;
    logic [47:0] r_phase_frame, n_phase_frame;
    logic [7:0]  r_button_state, n_button_state;
    logic [7:0]  r_button_previous, n_button_previous;
    logic        r_key_event, n_key_event;

    logic        req_accept;
    logic        out_take;
    t_opcode     op;

    // Decoded fields of a segment write command.
    logic        cmd_plane;
    logic        cmd_polarity;
    logic [2:0]  cmd_bit;
    logic [2:0]  cmd_byte;
    logic [7:0]  sel;
    logic [1:0]  phase;

    // The output register frees itself when its result is taken, so a new
    // request is taken in the same cycle as the old result leaves.
    assign o_ready    = !r_out_valid || i_ready;
    assign req_accept = i_valid && o_ready;
    assign out_take   = r_out_valid && i_ready;
    assign op         = t_opcode'(i_opcode);

    assign cmd_plane    = i_segment_command[0];
    assign cmd_polarity = i_segment_command[1];
    assign cmd_bit      = i_segment_command[4:2];
    assign cmd_byte     = i_segment_command[7:5];

    assign sel   = 8'(1) << r_tick;
    assign phase = r_tick[1:0];

    always_comb begin
        n_image           = r_image;
        n_frames          = r_frames;
        n_changed         = r_changed;
        n_tick            = r_tick;
        n_buttons         = r_buttons;
        n_reported        = r_reported;
        n_out_valid       = r_out_valid && !out_take;
        n_scan_select     = r_scan_select;
        n_phase_frame     = r_phase_frame;
        n_button_state    = r_button_state;
        n_button_previous = r_button_previous;
        n_key_event       = r_key_event;

        if (req_accept) begin
            case (op)
                OP_WRITE: begin
                    // Byte indexes past the frame leave the image alone but
                    // still force a relatch on the next frame boundary.
                    if (32'(cmd_byte) < FRAME_BYTES) begin
                        n_image[cmd_plane][cmd_byte][cmd_bit] =
                            (cmd_polarity == i_segment_on);
                    end
                    n_changed = 1'b1;
                end
                OP_CLEAR: begin
                    n_image   = default_image();
                    n_changed = 1'b1;
                end
                OP_TICK: begin
                    // The frame is read before any latch made by this tick.
                    for (int b = 0; b < FRAME_BYTES; b++) begin
                        n_phase_frame[8*(FRAME_BYTES-1-b) +: 8] = r_frames[phase][b];
                    end
                    n_buttons = i_button_level ? (r_buttons | sel) : (r_buttons & ~sel);
                    n_tick    = r_tick + 3'd1;
                    // A new AC cycle starts when the count wraps past phase 3.
                    if (phase == 2'd3 && r_changed) begin
                        n_changed = 1'b0;
                        n_frames  = build_frames(r_image);
                    end
                    n_key_event = 1'b0;
                    if (n_buttons != r_reported && r_key_en) begin
                        n_key_event = 1'b1;
                        n_reported  = n_buttons;
                    end
                    n_scan_select     = sel;
                    n_button_state    = n_buttons;
                    n_button_previous = r_reported;
                    n_out_valid       = 1'b1;
                end
                default: begin
                    // Unused opcode: the request is consumed with no effect.
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image     <= default_image();
            r_frames    <= '0;
            r_changed   <= 1'b1;
            r_tick      <= '0;
            r_buttons   <= '0;
            r_reported  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_image     <= n_image;
            r_frames    <= n_frames;
            r_changed   <= n_changed;
            r_tick      <= n_tick;
            r_buttons   <= n_buttons;
            r_reported  <= n_reported;
            r_out_valid <= n_out_valid;
        end
    end

    // Result payload carries no reset; it is qualified by the valid flag.
    always_ff @(posedge i_clk) begin
        r_scan_select     <= n_scan_select;
        r_phase_frame     <= n_phase_frame;
        r_button_state    <= n_button_state;
        r_button_previous <= n_button_previous;
        r_key_event       <= n_key_event;
    end

    // Configuration register. Bits 1:0 of the address are ignored, and
    // only word 0 holds a register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_en <= 1'b0;
        end else if (psel && penable && pwrite && pready && paddr[2] == REG_KEY_REPORT_ENABLE) begin
            r_key_en <= pwdata[0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_KEY_REPORT_ENABLE) ? {31'd0, r_key_en} : 32'd0;

    assign o_valid           = r_out_valid;
    assign o_scan_select     = r_scan_select;
    assign o_phase_frame     = r_phase_frame;
    assign o_button_state    = r_button_state;
    assign o_button_previous = r_button_previous;
    assign o_key_event       = r_key_event;

endmodule

// ===== rtl/acld_checker.sv =====
// Port-level checker for the AC multiplexed LCD driver, bound to the top level.
module acld_checker
    import acld_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic        o_ready,
    input  logic [1:0]  i_opcode,
    input  logic        o_valid,
    input  logic        i_ready,
    input  logic [7:0]  o_scan_select,
    input  logic [47:0] o_phase_frame,
    input  logic [7:0]  o_button_state,
    input  logic [7:0]  o_button_previous,
    input  logic        o_key_event
);

    // A stalled result keeps its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_scan_select)
            && $stable(o_phase_frame) && $stable(o_button_state)
            && $stable(o_button_previous) && $stable(o_key_event))
        else $error("result changed while stalled");

    // Every result selects exactly one scan line.
    a_scan_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $onehot(o_scan_select))
        else $error("scan select not one-hot");

    // A key event is only raised for a real change of the button bits.
    a_event_change: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_key_event |-> o_button_state != o_button_previous)
        else $error("key event without button change");

    // An accepted tick yields a result in the next cycle.
    a_tick_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready && i_opcode == OP_TICK |=> o_valid)
        else $error("tick request gave no result");

    // Write, clear and unused requests never create a result.
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid && !(i_valid && o_ready && i_opcode == OP_TICK) |=> !o_valid)
        else $error("result without a tick request");

endmodule

bind ac_lcd_multiplex_driver_top acld_checker u_acld_checker (.*);

// ===== test/ac_lcd_multiplex_driver_top_tb.sv =====
// Self-checking testbench for the AC multiplexed LCD driver with button scan.
`timescale 1ns / 100ps

import acld_pkg::*;

// Drive constants of the display.
localparam bit [7:0] COM_KEEP     = 8'hE3;
localparam bit [7:0] LED_MASK     = 8'h10;
localparam bit [7:0] LED_BYTE     = 8'h10;
localparam bit [7:0] DEFAULT_COM0 = 8'h14;
localparam bit [7:0] DEFAULT_COM1 = 8'h0C;
// Common bits forced into byte 0 of each drive phase, phase 0 in the low byte.
localparam bit [3:0][7:0] COM_DRIVE = {8'h14, 8'h0C, 8'h08, 8'h10};

typedef struct packed {
    bit [7:0]  sel;
    bit [47:0] frame;
    bit [7:0]  state;
    bit [7:0]  prev;
    bit        key_evt;
} t_scan_result;

class lcd_scan_scoreboard;
    bit [7:0]     image  [2][6];
    bit [7:0]     frames [4][6];
    bit           changed;
    bit [2:0]     tick;
    bit [7:0]     buttons;
    bit [7:0]     reported;
    bit           report_en;
    t_scan_result pending_scans [$];
    int           errors;

    function new();
        foreach (frames[p, b]) frames[p][b] = '0;
        restore_default();
        tick      = '0;
        buttons   = '0;
        reported  = '0;
        report_en = 1'b0;
        errors    = 0;
    endfunction

    function void restore_default();
        foreach (image[p, b]) image[p][b] = '0;
        for (int p = 0; p < 2; p++) begin
            image[p][4] = 8'hFF;
            image[p][5] = LED_BYTE;
        end
        image[0][0] = DEFAULT_COM0;
        image[1][0] = DEFAULT_COM1;
        changed = 1'b1;
    endfunction

    // Phases 0/1 are straight plane copies, 2/3 inverted, except the enable
    // byte and the LED bit, which stay true, and the forced common bits.
    function void relatch();
        for (int b = 0; b < 6; b++) begin
            frames[0][b] = image[0][b];
            frames[1][b] = image[1][b];
            frames[2][b] = ~image[0][b];
            frames[3][b] = ~image[1][b];
        end
        frames[2][4] = image[0][4];
        frames[3][4] = image[1][4];
        frames[2][5] = (image[0][5] & LED_MASK) | (~image[0][5] & ~LED_MASK);
        frames[3][5] = (image[1][5] & LED_MASK) | (~image[1][5] & ~LED_MASK);
        for (int k = 0; k < 4; k++) begin
            frames[k][0] = (frames[k][0] & COM_KEEP) | COM_DRIVE[k];
        end
    endfunction

    // Called for every accepted request; a tick queues its scan result.
    function void note_request(t_opcode op, bit [7:0] cmd, bit on, bit level);
        t_scan_result r;
        bit [2:0]     byte_idx;
        byte_idx = cmd[7:5];
        case (op)
            OP_WRITE: begin
                if (byte_idx < 6) begin
                    image[cmd[0]][byte_idx][cmd[4:2]] = (cmd[1] == on);
                end
                changed = 1'b1;
            end
            OP_CLEAR: restore_default();
            OP_TICK: begin
                r.sel   = 8'b1 << tick;
                r.frame = {frames[tick[1:0]][0], frames[tick[1:0]][1],
                           frames[tick[1:0]][2], frames[tick[1:0]][3],
                           frames[tick[1:0]][4], frames[tick[1:0]][5]};
                r.prev  = reported;
                buttons[tick] = level;
                tick++;
                if (tick[1:0] == 2'd0 && changed) begin
                    changed = 1'b0;
                    relatch();
                end
                r.key_evt = (buttons != reported) && report_en;
                if (r.key_evt) reported = buttons;
                r.state = buttons;
                pending_scans.push_back(r);
            end
            default: ;
        endcase
    endfunction

    function void compare_field(string name, bit [47:0] want, bit [47:0] got);
        if (want != got) begin
            errors++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
        end
    endfunction

    function void check_scan(bit [7:0] sel, bit [47:0] frame, bit [7:0] state,
                             bit [7:0] prev, bit key_evt);
        t_scan_result want;
        if (pending_scans.size() == 0) begin
            errors++;
            $display("%0t: scan result with none expected, expected nothing, %s",
                     $time, $sformatf("actual sel=%h frame=%h", sel, frame));
            return;
        end
        want = pending_scans.pop_front();
        compare_field("scan_select", 48'(want.sel), 48'(sel));
        compare_field("phase_frame", want.frame, frame);
        compare_field("button_state", 48'(want.state), 48'(state));
        compare_field("button_previous", 48'(want.prev), 48'(prev));
        compare_field("key_event", 48'(want.key_evt), 48'(key_evt));
    endfunction
endclass

module ac_lcd_multiplex_driver_top_tb;

    localparam int       CYCLE_LIMIT     = 200000;
    localparam int       RANDOM_PER_STEP = 256;
    localparam bit [2:0] KEY_REPORT_ADDR = {REG_KEY_REPORT_ENABLE, 2'b00};

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [1:0]  i_opcode;
    logic [7:0]  i_segment_command;
    logic        i_segment_on;
    logic        i_button_level;
    logic        o_valid;
    logic        i_ready;
    logic [7:0]  o_scan_select;
    logic [47:0] o_phase_frame;
    logic [7:0]  o_button_state;
    logic [7:0]  o_button_previous;
    logic        o_key_event;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    lcd_scan_scoreboard scoreboard;
    int                 cycles;
    // When set, neither side inserts idle cycles, giving back-to-back traffic.
    bit                 steady;
    // Button return line level; it changes only now and then so that the
    // sampled byte can settle and some ticks report no key change.
    bit                 line_level;

    ac_lcd_multiplex_driver_top dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_ready           (o_ready),
        .i_opcode          (i_opcode),
        .i_segment_command (i_segment_command),
        .i_segment_on      (i_segment_on),
        .i_button_level    (i_button_level),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_scan_select     (o_scan_select),
        .o_phase_frame     (o_phase_frame),
        .o_button_state    (o_button_state),
        .o_button_previous (o_button_previous),
        .o_key_event       (o_key_event),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Run-away guard: a hung handshake ends the run as a failure.
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("ac_lcd_multiplex_driver_top test failed");
            $finish;
        end
    end

    // Mostly no gap, often a short one, now and then a long one.
    function automatic int idle_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Drives one request after an optional idle gap and holds it until the
    // block takes it. Fields carry junk while valid is low.
    task automatic send_request(t_opcode op, bit [7:0] cmd, bit on, bit level);
        int gap;
        gap = idle_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            i_valid           <= 1'b0;
            i_opcode          <= 2'($urandom());
            i_segment_command <= 8'($urandom());
            i_segment_on      <= 1'($urandom());
            i_button_level    <= 1'($urandom());
            repeat (gap) @(negedge i_clk);
        end
        i_valid           <= 1'b1;
        i_opcode          <= op;
        i_segment_command <= cmd;
        i_segment_on      <= on;
        i_button_level    <= level;
        do @(posedge i_clk); while (!o_ready);
        scoreboard.note_request(op, cmd, on, level);
    endtask

    // Lets the block drain every expected scan result before the register
    // changes; writes and clears leave no result to wait for.
    task automatic wait_idle();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (scoreboard.pending_scans.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    // Register write in a setup phase, then an access phase, with pready always high.
    // Upper data bits are random since only bit 0 is meaningful.
    task automatic write_key_report(bit enable);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= KEY_REPORT_ADDR;
        pwdata  <= {31'($urandom()), enable};
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        scoreboard.report_en = enable;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Random traffic: ticks and segment writes dominate, with some clears
    // and unused-opcode requests mixed in. Full random commands also hit the
    // ignored byte indexes six and seven.
    task automatic random_requests(int count);
        t_opcode op;
        int      r;
        repeat (count) begin
            r = $urandom_range(0, 99);
            if ($urandom_range(0, 3) == 0) line_level = ~line_level;
            if (r < 45)      op = OP_TICK;
            else if (r < 88) op = OP_WRITE;
            else if (r < 94) op = OP_CLEAR;
            else             op = OP_NONE;
            send_request(op, 8'($urandom()), 1'($urandom()), line_level);
        end
    endtask

    // The result side stalls at random, independently of the request side.
    initial begin
        int stall;
        stall = 0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if (stall > 0) begin
                i_ready <= 1'b0;
                stall--;
            end else begin
                i_ready <= 1'b1;
                stall = idle_gap();
            end
        end
    end

    // Results are checked at the edge where they are taken.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            scoreboard.check_scan(o_scan_select, o_phase_frame, o_button_state,
                                  o_button_previous, o_key_event);
        end
    end

    initial begin
        scoreboard        = new();
        cycles            = 0;
        steady            = 1'b0;
        line_level        = 1'b0;
        i_clk             = 1'b0;
        i_rst_n           = 1'b0;
        i_valid           = 1'b0;
        i_opcode          = OP_NONE;
        i_segment_command = '0;
        i_segment_on      = 1'b0;
        i_button_level    = 1'b0;
        i_ready           = 1'b0;
        psel              = 1'b0;
        penable           = 1'b0;
        pwrite            = 1'b0;
        paddr             = '0;
        pwdata            = '0;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part, reporting off. The first four ticks show the zeroed
        // phase frames, and the fourth latches the default image.
        send_request(OP_TICK, 8'h00, 1'b0, 1'b1);
        send_request(OP_TICK, 8'h00, 1'b0, 1'b0);
        send_request(OP_TICK, 8'h00, 1'b0, 1'b1);
        send_request(OP_TICK, 8'h00, 1'b0, 1'b1);
        // Polarity against the on flag: clear with polarity low, set with it high.
        send_request(OP_WRITE, 8'h00, 1'b1, 1'b0);
        send_request(OP_WRITE, 8'h03, 1'b1, 1'b0);
        // Byte indexes seven and six touch no bit but still mark a change.
        send_request(OP_WRITE, 8'hFF, 1'b0, 1'b1);
        send_request(OP_WRITE, 8'hC2, 1'b1, 1'b1);
        // Top bit of the LED byte in both planes, then bit 4 of the enable
        // byte set and cleared again.
        send_request(OP_WRITE, 8'hBF, 1'b1, 1'b0);
        send_request(OP_WRITE, 8'hBE, 1'b0, 1'b0);
        send_request(OP_WRITE, 8'h92, 1'b1, 1'b0);
        send_request(OP_WRITE, 8'h90, 1'b1, 1'b0);
        // The unused opcode must leave everything alone.
        send_request(OP_NONE, 8'hFF, 1'b1, 1'b1);
        // A full turn of the scan: every select bit and two latch points.
        send_request(OP_TICK, 8'h00, 1'b0, 1'b0);
        send_request(OP_TICK, 8'h00, 1'b0, 1'b1);
        send_request(OP_TICK, 8'h00, 1'b0, 1'b0);
        send_request(OP_TICK, 8'h00, 1'b0, 1'b1);
        send_request(OP_TICK, 8'h00, 1'b0, 1'b1);
        send_request(OP_TICK, 8'h00, 1'b0, 1'b1);
        send_request(OP_TICK, 8'h00, 1'b0, 1'b1);
        send_request(OP_TICK, 8'h00, 1'b0, 1'b1);
        // Clearing brings back the default image at the next latch.
        send_request(OP_CLEAR, 8'hA5, 1'b1, 1'b0);
        send_request(OP_TICK, 8'h00, 1'b0, 1'b0);
        send_request(OP_TICK, 8'h00, 1'b0, 1'b0);

        // Random part over alternating reporting settings; the third step
        // runs without any idle cycles on either side.
        wait_idle();
        write_key_report(1'b1);
        random_requests(RANDOM_PER_STEP);
        wait_idle();
        write_key_report(1'b0);
        random_requests(RANDOM_PER_STEP);
        wait_idle();
        write_key_report(1'b1);
        steady = 1'b1;
        random_requests(RANDOM_PER_STEP);
        wait_idle();
        steady = 1'b0;
        write_key_report(1'b0);
        random_requests(RANDOM_PER_STEP);

        wait_idle();
        repeat (10) @(negedge i_clk);
        if (scoreboard.pending_scans.size() != 0) begin
            $display("%0t: scan results outstanding, expected 0, actual %0d", $time,
                     scoreboard.pending_scans.size());
        end
        if (scoreboard.errors == 0 && scoreboard.pending_scans.size() == 0) begin
            $display("ac_lcd_multiplex_driver_top test passed");
        end else begin
            $display("ac_lcd_multiplex_driver_top test failed");
        end
        $finish;
    end

endmodule
